// ===== sv/mandelbrot_escape_count_macros.svh =====
// Assertion macros for the Mandelbrot escape counter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MANDELBROT_ESCAPE_COUNT_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MEC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mec_pkg.sv =====
// Shared types and constants for the Mandelbrot escape counter.
// No dependencies; imported by the controller, datapath and top level.
package mec_pkg;

    // coordinate format: signed fixed point, FRAC_BITS fraction bits
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 28;
    localparam int COUNT_W   = 16;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 1;

    // |z|^2 > 4 with 2*FRAC_BITS fraction bits means sum > 2^(2*FRAC_BITS+2)
    localparam logic [SUM_W-1:0] ESCAPE_BOUND =
        {{(SUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_ITER_LIMIT = 3'd0;
    localparam logic [COUNT_W-1:0] ITER_LIMIT_RESET = 16'd100;

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new point, z = c, index = 1
        logic mul_en;    // register the three products of z
        logic upd_en;    // z = z^2 + c, index + 1
        logic res_load;  // write the result register
    } mec_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic escape;    // squares of current z sum above 4
        logic more;      // next index is still under the limit
    } mec_status_t;

endpackage

// ===== sv/mec_ctrl.sv =====
// Sequencer for the escape counter: accepts points, steps the iteration,
// owns the result valid flag. Depends on mec_pkg.
module mec_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pt_valid,
    output logic                 pt_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    input  mec_pkg::mec_status_t status,
    output mec_pkg::mec_cmd_t    cmd
);
    import mec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_TEST,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    // result register can take a new value this cycle
    assign out_free = !res_valid_reg || !res_stall;

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && pt_valid;
        cmd.mul_en   = (state_reg == S_MUL);
        cmd.upd_en   = (state_reg == S_TEST) && !status.escape && status.more;
        cmd.res_load = (state_reg == S_FIN) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pt_valid)
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_TEST;
            S_TEST:
            begin
                if (status.escape || !status.more)
                    state_next = S_FIN;
                else
                    state_next = S_MUL;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // result valid: set on load, cleared when taken
    always_comb
    begin
        if (cmd.res_load)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign pt_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

// ===== sv/mec_datapath.sv =====
// Datapath for the escape counter: z registers, three 32x32 multipliers,
// magnitude test, z update and result register. Depends on mec_pkg.
module mec_datapath (
    input  logic                              clk,
    input  logic signed [mec_pkg::COORD_W-1:0] c_real,
    input  logic signed [mec_pkg::COORD_W-1:0] c_imag,
    input  logic        [mec_pkg::COUNT_W-1:0] iter_limit,
    input  mec_pkg::mec_cmd_t                 cmd,
    output mec_pkg::mec_status_t              status,
    output logic        [mec_pkg::COUNT_W-1:0] escape_count
);
    import mec_pkg::*;

    logic signed [COORD_W-1:0] c_real_reg, c_imag_reg;
    logic signed [COORD_W-1:0] z_real_reg, z_imag_reg;
    logic signed [COORD_W-1:0] z_real_next, z_imag_next;
    logic        [COUNT_W-1:0] index_reg;
    logic signed [PROD_W-1:0]  xx_reg, yy_reg, xy_reg;
    logic signed [PROD_W-1:0]  xx_next, yy_next, xy_next;
    logic signed [PROD_W-1:0]  diff, re_shift, im_shift, re_sum, im_sum;
    logic        [SUM_W-1:0]   sq_sum;
    logic        [COUNT_W:0]   index_inc;
    logic        [COUNT_W-1:0] escape_count_reg;

    // products of the current z, exact at double width
    always_comb
    begin
        xx_next = PROD_W'(z_real_reg) * PROD_W'(z_real_reg);
        yy_next = PROD_W'(z_imag_reg) * PROD_W'(z_imag_reg);
        xy_next = PROD_W'(z_real_reg) * PROD_W'(z_imag_reg);
    end

    // magnitude test and limit check
    assign sq_sum    = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign index_inc = {1'b0, index_reg} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        status        = '0;
        status.escape = (sq_sum > ESCAPE_BOUND);
        status.more   = (index_inc < {1'b0, iter_limit});
    end

    // z^2 + c with floor shifts back to the coordinate format
    always_comb
    begin
        diff        = xx_reg - yy_reg;
        re_shift    = diff >>> FRAC_BITS;
        im_shift    = xy_reg >>> (FRAC_BITS - 1);
        re_sum      = re_shift + {{(PROD_W-COORD_W){c_real_reg[COORD_W-1]}}, c_real_reg};
        im_sum      = im_shift + {{(PROD_W-COORD_W){c_imag_reg[COORD_W-1]}}, c_imag_reg};
        z_real_next = re_sum[COORD_W-1:0];
        z_imag_next = im_sum[COORD_W-1:0];
    end

    // iteration 0 always gives z = c, so a point starts at index 1
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_real_reg <= c_real;
            c_imag_reg <= c_imag;
            z_real_reg <= c_real;
            z_imag_reg <= c_imag;
            index_reg  <= {{(COUNT_W-1){1'b0}}, 1'b1};
        end
        else if (cmd.upd_en)
        begin
            z_real_reg <= z_real_next;
            z_imag_reg <= z_imag_next;
            index_reg  <= index_inc[COUNT_W-1:0];
        end
        if (cmd.mul_en)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            xy_reg <= xy_next;
        end
        // escaped: report the index; bounded within the limit: zero
        if (cmd.res_load)
            escape_count_reg <= status.escape ? index_reg : '0;
    end

    assign escape_count = escape_count_reg;

endmodule

// ===== sv/mandelbrot_escape_count.sv =====
// Top level of the Mandelbrot escape counter: configuration register,
// controller and datapath. Depends on mec_pkg, mec_ctrl, mec_datapath.
// Usage:
//   Point channel (pt_valid/pt_stall, c_real, c_imag): one complex point per
//   item, signed Q4.28. Result channel (res_valid/res_stall, escape_count):
//   one count per point, in order.
//   escape_count is the first iteration index at which |z|^2 > 4, 1 when |c|
//   is already above 2, 0 when z stays bounded within iteration_limit.
//   Register iteration_limit lies at address 0 (reset 100); write it only
//   while no point is in flight.
// Sequence:
//   Each z = z^2 + c step runs through state S_MUL, which registers the three
//   32x32 products, then state S_TEST, which does the magnitude test and the
//   update. The loop ends on escape or when the next index would reach
//   iteration_limit. A point is taken only while the sequencer is idle, so the
//   next point is accepted only after the result of the last one is loaded.
// Reset and stall:
//   rst_n clears the sequencer and the result flag and sets the limit to 100.
//   A stalled result holds; the next point is still accepted and computed,
//   and waits for the result register before it completes.
module mandelbrot_escape_count (
    input  logic                               clk,
    input  logic                               rst_n,
    // point channel
    input  logic                               pt_valid,
    output logic                               pt_stall,
    input  logic signed [mec_pkg::COORD_W-1:0] c_real,
    input  logic signed [mec_pkg::COORD_W-1:0] c_imag,
    // result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic        [mec_pkg::COUNT_W-1:0] escape_count,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic        [mec_pkg::ADDR_W-1:0]  paddr,
    input  logic        [mec_pkg::DATA_W-1:0]  pwdata,
    output logic        [mec_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);
    import mec_pkg::*;

    `include "mandelbrot_escape_count_macros.svh"

    logic [COUNT_W-1:0] iter_limit_reg, iter_limit_next;
    logic               cfg_write;
    mec_cmd_t           cmd;
    mec_status_t        status;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        iter_limit_next = iter_limit_reg;
        if (cfg_write && (paddr == ADDR_ITER_LIMIT))
            iter_limit_next = pwdata[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_limit_reg <= ITER_LIMIT_RESET;
        else
            iter_limit_reg <= iter_limit_next;
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_ITER_LIMIT)
            prdata = {{(DATA_W-COUNT_W){1'b0}}, iter_limit_reg};
    end

    mec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mec_datapath u_datapath (
        .clk          (clk),
        .c_real       (c_real),
        .c_imag       (c_imag),
        .iter_limit   (iter_limit_reg),
        .cmd          (cmd),
        .status       (status),
        .escape_count (escape_count)
    );

    // checks
    `MEC_ASSERT_NEXT(a_busy_after_accept, pt_valid && !pt_stall, pt_stall,
        "point channel not busy after an accepted item")
    `MEC_ASSERT_IMPL(a_no_result_overwrite, cmd.res_load, !(res_valid && res_stall),
        "result register written while a stalled result is pending")
    `MEC_ASSERT_IMPL(a_count_in_range, res_valid,
        (escape_count == '0) || (escape_count == COUNT_W'(1)) ||
        (escape_count < iter_limit_reg),
        "escape count outside the iteration limit")
    `MEC_ASSERT_IMPL(a_single_command, 1'b1, $onehot0({cmd.load, cmd.mul_en, cmd.upd_en}),
        "controller issued conflicting datapath commands")

endmodule

// ===== dv/tb_mandelbrot_escape_count.sv =====
// Self-checking testbench for the Mandelbrot escape counter.
// Depends on mec_pkg and mandelbrot_escape_count; drives points and limits, checks counts.
module tb_mandelbrot_escape_count;
    import mec_pkg::*;

    // Q4.28 constants
    localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh1000_0000;
    localparam logic signed [COORD_W-1:0] Q_TWO = 32'sh2000_0000;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
    // |z|^2 > 4 at 2*FRAC_BITS fraction bits
    localparam longint unsigned MAG_LIMIT = 64'd1 << (2 * FRAC_BITS + 2);

    typedef struct {
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
        logic        [COUNT_W-1:0] count;
    } point_expect_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      pt_valid = 1'b0;
    logic                      pt_stall;
    logic signed [COORD_W-1:0] c_real = '0;
    logic signed [COORD_W-1:0] c_imag = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    logic        [COUNT_W-1:0] escape_count;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic        [ADDR_W-1:0]  paddr = '0;
    logic        [DATA_W-1:0]  pwdata = '0;
    logic        [DATA_W-1:0]  prdata;
    logic                      pready;

    point_expect_t      pending_counts[$];
    logic [COUNT_W-1:0] limit_shadow = ITER_LIMIT_RESET;
    int                 mismatch_count = 0;
    bit                 traffic_idle = 1'b1;
    int                 tx_calm = 0;
    int                 rx_stall_left = 0;
    int                 rx_calm = 0;

    mandelbrot_escape_count uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pt_valid     (pt_valid),
        .pt_stall     (pt_stall),
        .c_real       (c_real),
        .c_imag       (c_imag),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .escape_count (escape_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // escape index of one point: 1 for early reject, 0 when bounded
    function automatic logic [COUNT_W-1:0] predict_escape(
        input logic signed [COORD_W-1:0] cr,
        input logic signed [COORD_W-1:0] ci,
        input logic        [COUNT_W-1:0] limit
    );
        longint                    x;
        longint                    y;
        longint                    xy;
        longint                    nx;
        longint                    ny;
        longint unsigned           xx;
        longint unsigned           yy;
        logic signed [COORD_W-1:0] zr;
        logic signed [COORD_W-1:0] zi;
        int                        n;
        x = cr;
        y = ci;
        xx = x * x;
        yy = y * y;
        if (xx + yy > MAG_LIMIT)
            return COUNT_W'(1);
        zr = '0;
        zi = '0;
        for (n = 0; n < limit; n++)
        begin
            x = zr;
            y = zi;
            xx = x * x;
            yy = y * y;
            xy = x * y;
            // test uses the squares of the old z
            if (xx + yy > MAG_LIMIT)
                return n[COUNT_W-1:0];
            // arithmetic shift gives floor rounding
            nx = ((longint'(xx) - longint'(yy)) >>> FRAC_BITS) + cr;
            ny = (xy >>> (FRAC_BITS - 1)) + ci;
            zr = nx[COORD_W-1:0];
            zi = ny[COORD_W-1:0];
        end
        return '0;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_q(input real lo, input real hi);
        real r;
        r = lo + (hi - lo) * $urandom_range(0, 65535) / 65535.0;
        return $rtoi(r * 268435456.0);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // result check and receiver stall bursts
    always @(posedge clk)
    begin
        point_expect_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_counts.size() == 0)
                    report_mismatch($sformatf("unexpected count %0d", escape_count));
                else
                begin
                    want = pending_counts.pop_front();
                    if (escape_count !== want.count)
                        report_mismatch($sformatf("c=(%h,%h) count %0d, want %0d",
                            want.cr, want.ci, escape_count, want.count));
                end
            end
            if (!traffic_idle)
                res_stall <= 1'b0;
            else if (rx_stall_left > 0)
            begin
                res_stall <= 1'b1;
                rx_stall_left--;
            end
            else if (rx_calm > 0)
            begin
                res_stall <= 1'b0;
                rx_calm--;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        res_stall <= 1'b1;
                        rx_stall_left = $urandom_range(1, 18) - 1;
                    end
                    3:
                    begin
                        res_stall <= 1'b0;
                        rx_calm = $urandom_range(20, 200);
                    end
                    default:
                        res_stall <= 1'b0;
                endcase
            end
        end
    end

    // one point item, with an optional idle burst ahead of it
    task automatic send_point(input logic signed [COORD_W-1:0] cr,
                              input logic signed [COORD_W-1:0] ci);
        int            gap;
        point_expect_t entry;
        gap = 0;
        if (traffic_idle)
        begin
            if (tx_calm > 0)
                tx_calm--;
            else if ($urandom_range(0, 19) == 0)
                tx_calm = $urandom_range(10, 60);
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 18);
        end
        if (gap > 0)
        begin
            pt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_valid <= 1'b1;
        c_real <= cr;
        c_imag <= ci;
        @(posedge clk);
        while (pt_stall)
            @(posedge clk);
        entry.cr = cr;
        entry.ci = ci;
        entry.count = predict_escape(cr, ci, limit_shadow);
        pending_counts.push_back(entry);
    endtask

    // hold off the sender until every count is back
    task automatic wait_results_drained();
        pt_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // idle the block, write the limit with junk above bit 15, read it back
    task automatic program_limit(input logic [COUNT_W-1:0] limit);
        logic [DATA_W-1:0] rd;
        wait_results_drained();
        apb_write(ADDR_ITER_LIMIT, {16'($urandom()), limit});
        limit_shadow = limit;
        // the bus goes idle between the write and the read
        @(posedge clk);
        apb_read(ADDR_ITER_LIMIT, rd);
        if (rd[COUNT_W-1:0] !== limit)
            report_mismatch($sformatf("limit reads %0d, want %0d", rd[COUNT_W-1:0], limit));
    endtask

    task automatic test_reset_limit();
        logic [DATA_W-1:0] rd;
        apb_read(ADDR_ITER_LIMIT, rd);
        if (rd[COUNT_W-1:0] !== ITER_LIMIT_RESET)
            report_mismatch($sformatf("reset limit reads %0d", rd[COUNT_W-1:0]));
        send_point('0, '0);
        // exactly on |c| = 2, then one step outside
        send_point(Q_TWO, '0);
        send_point(Q_TWO + 1, '0);
        send_point(-Q_TWO, '0);
        send_point('0, Q_TWO);
        send_point('0, -Q_TWO);
        send_point(-Q_TWO, 32'sd1);
        // full-range components
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        // tiny negative values exercise floor rounding
        send_point(-32'sd1, -32'sd1);
        send_point(Q_ONE, '0);
        send_point(-Q_ONE, '0);
        send_point(rand_q(0.3, 0.3), rand_q(0.5, 0.5));
        send_point(rand_q(-0.75, -0.75), rand_q(0.1, 0.1));
    endtask

    task automatic test_zero_limit();
        program_limit('0);
        send_point('0, '0);
        send_point(Q_ONE, '0);
        send_point(Q_TWO + 1, '0);
    endtask

    task automatic test_limit_one();
        program_limit(16'd1);
        send_point('0, '0);
        send_point(Q_ONE, '0);
        send_point(Q_TWO + 1, Q_MIN);
    endtask

    task automatic test_max_limit();
        program_limit(16'hFFFF);
        send_point(Q_MIN, '0);
        send_point(Q_ONE, '0);
        // just past the cusp: escapes only after a very long orbit
        send_point((Q_ONE >>> 2) + 1, '0);
        send_point('0, '0);
    endtask

    // random point drawn from regions with different escape behavior
    task automatic send_random_point();
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
        int                        pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            cr = $urandom();
            ci = $urandom();
        end
        else if (pick < 55)
        begin
            cr = rand_q(-2.0, 2.0);
            ci = rand_q(-2.0, 2.0);
        end
        else if (pick < 80)
        begin
            cr = rand_q(-2.0, 0.5);
            ci = rand_q(-1.2, 1.2);
        end
        else if (pick < 86)
        begin
            cr = rand_q(-0.5, 0.2);
            ci = rand_q(-0.4, 0.4);
        end
        else if (pick < 92)
        begin
            cr = rand_q(-1.2, -0.8);
            ci = rand_q(-0.15, 0.15);
        end
        else
        begin
            // on the |c| = 2 boundary, give or take one LSB
            cr = ($urandom_range(0, 1) ? Q_TWO : -Q_TWO) + $signed($urandom_range(0, 2)) - 1;
            ci = $signed($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
            begin
                ci = cr;
                cr = $signed($urandom_range(0, 2)) - 1;
            end
        end
        send_point(cr, ci);
    endtask

    task automatic test_random_points();
        int phase;
        int items;
        int k;
        for (phase = 0; phase < 14; phase++)
        begin
            items = 100;
            case (phase)
                0: begin program_limit(16'd0); items = 40; end
                1: begin program_limit(16'd1); items = 40; end
                2: begin program_limit(16'd2); items = 40; end
                3: begin program_limit(16'($urandom_range(200, 1000))); items = 20; end
                default: program_limit(16'($urandom_range(1, 128)));
            endcase
            for (k = 0; k < items; k++)
                send_random_point();
        end
    endtask

    task automatic test_no_idle();
        int k;
        program_limit(16'($urandom_range(1, 64)));
        traffic_idle = 1'b0;
        for (k = 0; k < 100; k++)
            send_random_point();
    endtask

    initial
    begin
        int drain_wait;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limit();
        test_zero_limit();
        test_limit_one();
        test_max_limit();
        test_random_points();
        test_no_idle();
        pt_valid <= 1'b0;
        drain_wait = 0;
        while (pending_counts.size() != 0 && drain_wait < 200000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        // allow for a stray late count
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pending_counts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #(40_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
